// ===== rtl/pfc_pkg.sv =====
// pfc_pkg: shared types, constants and helpers for the playfair digraph cipher core
// depends on nothing; used by every module under rtl
package pfc_pkg;

   localparam int unsigned SqDim     = 5;
   localparam int unsigned CodeWidth = 5;
   localparam int unsigned RowWidth  = SqDim * CodeWidth;
   localparam int unsigned IdxWidth  = $clog2(SqDim);
   localparam int unsigned CsrIdxWidth = 3;

   localparam logic [IdxWidth-1:0] IdxFirst = '0;
   localparam logic [IdxWidth-1:0] IdxLast  = IdxWidth'(SqDim - 1);

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CsrSquareRow0 = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrSquareRow1 = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrSquareRow2 = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrSquareRow3 = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrSquareRow4 = 3'd4;

   localparam logic MODE_DECRYPT = 1'b0;
   localparam logic MODE_ENCRYPT = 1'b1;

   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [IdxWidth-1:0]  idx_type;
   typedef logic [SqDim-1:0][RowWidth-1:0] square_type;

   // rows a..e, f..j, k..o, p r s t u, v..z
   localparam square_type SquareReset = {
      25'd27025109, 25'd21613103, 25'd15118698, 25'd9706693, 25'd4294688
   };

   typedef struct packed {
      code_type first_letter;
      code_type second_letter;
      logic     mode;
      logic     last_pair;
   } req_type;

   typedef struct packed {
      code_type out_first;
      code_type out_second;
      logic     letter_missing;
      logic     last_out;
   } rsp_type;

   typedef struct packed {
      logic    found;
      idx_type row;
      idx_type col;
   } loc_type;

   function automatic code_type pfc_cell(input square_type sq, input idx_type row,
                                         input idx_type col);
      logic [RowWidth-1:0] row_bits;
      row_bits = sq[row];
      return row_bits[col*CodeWidth +: CodeWidth];
   endfunction

endpackage

// ===== rtl/playfair_digraph_cipher_core.sv =====
// playfair_digraph_cipher_core: top level, input register, cipher logic, result register
// depends on pfc_pkg, pfc_key_square, pfc_digraph
//
// One letter pair goes in per beat and one result comes out per beat. The pair is
// captured in an input register, the key square lookup and the playfair rule are
// combinational, and the result lands in an output register. The output stage moves
// when the result is taken or the output is empty, the input stage also when it is
// empty; the core sustains one pair per clock while results are taken. Key square rows
// are written over the always-ready csr channel; write only while no pair is in flight.
module playfair_digraph_cipher_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pfc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pfc_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [pfc_pkg::RowWidth-1:0]    csr_wdata
);

   pfc_pkg::square_type square;
   pfc_pkg::req_type    req_ff, req_in;
   pfc_pkg::rsp_type    rsp_ff, rsp_in, rsp_calc;
   logic                req_valid_ff, req_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                adv_out, adv_in;

   pfc_key_square u_key_square (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .square    (square)
   );

   pfc_digraph u_digraph (
      .square (square),
      .req    (req_ff),
      .rsp    (rsp_calc)
   );

   assign adv_out   = !rsp_valid_ff || rsp_ready;
   assign adv_in    = !req_valid_ff || adv_out;
   assign req_ready = adv_in;

   always_comb begin
      req_valid_in = adv_in ? req_valid : req_valid_ff;
      rsp_valid_in = adv_out ? req_valid_ff : rsp_valid_ff;
      req_in       = (req_valid && adv_in) ? req_data : req_ff;
      rsp_in       = (req_valid_ff && adv_out) ? rsp_calc : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/pfc_key_square.sv =====
// pfc_key_square: five row registers of the key square, written over the csr channel
// depends on pfc_pkg
module pfc_key_square (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfc_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [pfc_pkg::RowWidth-1:0]    csr_wdata,
   output pfc_pkg::square_type             square
);

   pfc_pkg::square_type square_ff;
   pfc_pkg::square_type square_in;

   always_comb begin
      square_in = square_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pfc_pkg::CsrSquareRow0: square_in[0] = csr_wdata;
            pfc_pkg::CsrSquareRow1: square_in[1] = csr_wdata;
            pfc_pkg::CsrSquareRow2: square_in[2] = csr_wdata;
            pfc_pkg::CsrSquareRow3: square_in[3] = csr_wdata;
            pfc_pkg::CsrSquareRow4: square_in[4] = csr_wdata;
            default:                square_in = square_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff <= pfc_pkg::SquareReset;
      end else begin
         square_ff <= square_in;
      end
   end

   assign csr_ready = 1'b1;
   assign square    = square_ff;

endmodule

// ===== rtl/pfc_locate.sv =====
// pfc_locate: finds one letter in the key square, first match in row-major order
// depends on pfc_pkg
module pfc_locate (
   input  pfc_pkg::square_type square,
   input  pfc_pkg::code_type   letter,
   output pfc_pkg::loc_type    loc
);

   always_comb begin
      loc = '0;
      // scan backwards so the earliest match wins
      for (int r = pfc_pkg::SqDim - 1; r >= 0; r--) begin
         for (int c = pfc_pkg::SqDim - 1; c >= 0; c--) begin
            if (pfc_pkg::pfc_cell(square, pfc_pkg::IdxWidth'(r),
                                  pfc_pkg::IdxWidth'(c)) == letter) begin
               loc.found = 1'b1;
               loc.row   = pfc_pkg::IdxWidth'(r);
               loc.col   = pfc_pkg::IdxWidth'(c);
            end
         end
      end
   end

endmodule

// ===== rtl/pfc_digraph.sv =====
// pfc_digraph: playfair rule for one letter pair against the key square
// depends on pfc_pkg and pfc_locate
module pfc_digraph (
   input  pfc_pkg::square_type square,
   input  pfc_pkg::req_type    req,
   output pfc_pkg::rsp_type    rsp
);

   pfc_pkg::loc_type loc_a;
   pfc_pkg::loc_type loc_b;
   pfc_pkg::idx_type ra, ca, rb, cb;

   function automatic pfc_pkg::idx_type step_idx(input pfc_pkg::idx_type idx,
                                                 input logic mode);
      pfc_pkg::idx_type nxt;
      if (mode == pfc_pkg::MODE_ENCRYPT) begin
         nxt = (idx == pfc_pkg::IdxLast) ? pfc_pkg::IdxFirst : idx + 1'b1;
      end else begin
         nxt = (idx == pfc_pkg::IdxFirst) ? pfc_pkg::IdxLast : idx - 1'b1;
      end
      return nxt;
   endfunction

   pfc_locate u_locate_a (
      .square (square),
      .letter (req.first_letter),
      .loc    (loc_a)
   );

   pfc_locate u_locate_b (
      .square (square),
      .letter (req.second_letter),
      .loc    (loc_b)
   );

   always_comb begin
      priority if (loc_a.col == loc_b.col) begin
         ra = step_idx(loc_a.row, req.mode);
         rb = step_idx(loc_b.row, req.mode);
         ca = loc_a.col;
         cb = loc_b.col;
      end else if (loc_a.row == loc_b.row) begin
         ra = loc_a.row;
         rb = loc_b.row;
         ca = step_idx(loc_a.col, req.mode);
         cb = step_idx(loc_b.col, req.mode);
      end else begin
         ra = loc_a.row;
         rb = loc_b.row;
         ca = loc_b.col;
         cb = loc_a.col;
      end
   end

   always_comb begin
      rsp.last_out       = req.last_pair;
      rsp.letter_missing = !loc_a.found || !loc_b.found;
      if (rsp.letter_missing) begin
         rsp.out_first  = '0;
         rsp.out_second = '0;
      end else begin
         rsp.out_first  = pfc_pkg::pfc_cell(square, ra, ca);
         rsp.out_second = pfc_pkg::pfc_cell(square, rb, cb);
      end
   end

endmodule

// ===== verif/playfair_digraph_cipher_core_test.sv =====
// playfair_digraph_cipher_core_test: self-checking bench for the playfair digraph cipher core
// depends on pfc_pkg and playfair_digraph_cipher_core; drives pair, result and csr channels
// under random stalls; checks each result against a table answer or in-bench cipher predictor
module playfair_digraph_cipher_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DrainCycles = 4;
   localparam int LimitCycles = 400000;
   localparam int PairsPerPhase = 83;

   localparam logic LetterPresent = 1'b0;
   localparam logic LetterAbsent  = 1'b1;

   localparam logic [pfc_pkg::CsrIdxWidth-1:0] CsrFirstUnused = pfc_pkg::CsrSquareRow4 + 1'b1;
   localparam logic [pfc_pkg::CsrIdxWidth-1:0] CsrLastUnused  = '1;

   typedef enum int {SqShuffled, SqRandom, SqZeros, SqOnes, SqReset} square_kind_type;

   typedef struct {
      bit               typed;
      pfc_pkg::rsp_type answer;
   } table_answer_type;

   typedef struct {
      pfc_pkg::req_type pair;
      bit               typed;
      pfc_pkg::rsp_type answer;
   } vector_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   pfc_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   pfc_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [pfc_pkg::CsrIdxWidth-1:0] csr_index = pfc_pkg::CsrSquareRow0;
   logic [pfc_pkg::RowWidth-1:0]    csr_wdata = '0;

   pfc_pkg::square_type key_rows = pfc_pkg::SquareReset;
   pfc_pkg::rsp_type    cipher_results_due[$];
   table_answer_type    table_answers[$];

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int pairs_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   playfair_digraph_cipher_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic pfc_pkg::code_type letter_at(input int row, input int col);
      return key_rows[row][col*pfc_pkg::CodeWidth +: pfc_pkg::CodeWidth];
   endfunction

   // first match in row-major order wins
   function automatic void find_letter(input pfc_pkg::code_type code, output bit hit,
                                       output int row, output int col);
      hit = 1'b0;
      row = 0;
      col = 0;
      for (int r = 0; r < pfc_pkg::SqDim; r++) begin
         for (int c = 0; c < pfc_pkg::SqDim; c++) begin
            if (!hit && letter_at(r, c) == code) begin
               hit = 1'b1;
               row = r;
               col = c;
            end
         end
      end
   endfunction

   function automatic pfc_pkg::rsp_type cipher_pair(input pfc_pkg::req_type p);
      pfc_pkg::rsp_type r;
      bit               hit_a;
      bit               hit_b;
      int               ar, ac, br, bc, step;
      r = '0;
      r.last_out = p.last_pair;
      find_letter(p.first_letter, hit_a, ar, ac);
      find_letter(p.second_letter, hit_b, br, bc);
      step = (p.mode == pfc_pkg::MODE_ENCRYPT) ? 1 : pfc_pkg::SqDim - 1;
      if (!hit_a || !hit_b) begin
         r.letter_missing = LetterAbsent;
      end else if (ac == bc) begin
         r.out_first  = letter_at((ar + step) % pfc_pkg::SqDim, ac);
         r.out_second = letter_at((br + step) % pfc_pkg::SqDim, bc);
      end else if (ar == br) begin
         r.out_first  = letter_at(ar, (ac + step) % pfc_pkg::SqDim);
         r.out_second = letter_at(br, (bc + step) % pfc_pkg::SqDim);
      end else begin
         r.out_first  = letter_at(ar, bc);
         r.out_second = letter_at(br, ac);
      end
      return r;
   endfunction

   function automatic vector_row_type vec(input pfc_pkg::code_type a,
                                          input pfc_pkg::code_type b, input logic m,
                                          input logic l, input bit typed = 1'b0,
                                          input pfc_pkg::code_type oa = '0,
                                          input pfc_pkg::code_type ob = '0,
                                          input logic miss = LetterPresent);
      vector_row_type v;
      v.pair   = {a, b, m, l};
      v.typed  = typed;
      v.answer = {oa, ob, miss, l};
      return v;
   endfunction

   // mostly letters taken from the square, biased toward shared rows and columns
   function automatic pfc_pkg::req_type random_pair();
      pfc_pkg::req_type p;
      int               kind, r1, c1, r2, c2;
      kind = $urandom_range(9);
      r1 = $urandom_range(pfc_pkg::SqDim - 1);
      c1 = $urandom_range(pfc_pkg::SqDim - 1);
      r2 = $urandom_range(pfc_pkg::SqDim - 1);
      c2 = $urandom_range(pfc_pkg::SqDim - 1);
      if (kind < 3) begin
         r2 = r1;
      end else if (kind < 6) begin
         c2 = c1;
      end else if (kind == 6) begin
         r2 = r1;
         c2 = c1;
      end
      p.first_letter  = letter_at(r1, c1);
      p.second_letter = letter_at(r2, c2);
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(1) == 1) p.first_letter = $urandom_range(31);
         else p.second_letter = $urandom_range(31);
      end
      p.mode      = $urandom_range(1) ? pfc_pkg::MODE_ENCRYPT : pfc_pkg::MODE_DECRYPT;
      p.last_pair = $urandom_range(1);
      return p;
   endfunction

   function automatic pfc_pkg::square_type make_square(input square_kind_type kind);
      pfc_pkg::square_type sq;
      pfc_pkg::code_type   deck[26];
      pfc_pkg::code_type   swap;
      int                  j;
      case (kind)
         SqShuffled: begin
            for (int i = 0; i < 26; i++) deck[i] = i;
            for (int i = 25; i > 0; i--) begin
               j = $urandom_range(i);
               swap = deck[i];
               deck[i] = deck[j];
               deck[j] = swap;
            end
            for (int r = 0; r < pfc_pkg::SqDim; r++)
               for (int c = 0; c < pfc_pkg::SqDim; c++)
                  sq[r][c*pfc_pkg::CodeWidth +: pfc_pkg::CodeWidth] = deck[r*pfc_pkg::SqDim + c];
         end
         SqRandom: begin
            for (int r = 0; r < pfc_pkg::SqDim; r++) sq[r] = pfc_pkg::RowWidth'($urandom());
         end
         SqZeros: sq = '0;
         SqOnes:  sq = '1;
         default: sq = pfc_pkg::SquareReset;
      endcase
      return sq;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("cycle %0d: %s", cycle_count, what);
   endtask

   task automatic send_pair(input pfc_pkg::req_type p, input bit typed = 1'b0,
                            input pfc_pkg::rsp_type answer = '0);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      table_answers.push_back('{typed: typed, answer: answer});
      req_valid <= 1'b1;
      req_data  <= p;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      pairs_sent++;
   endtask

   task automatic write_csr(input logic [pfc_pkg::CsrIdxWidth-1:0] idx,
                            input logic [pfc_pkg::RowWidth-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // the unmapped write goes last so the square is settled before new pairs are drawn
   task automatic load_square(input pfc_pkg::square_type sq);
      while (results_checked != pairs_sent) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      write_csr(pfc_pkg::CsrSquareRow0, sq[0]);
      write_csr(pfc_pkg::CsrSquareRow1, sq[1]);
      write_csr(pfc_pkg::CsrSquareRow2, sq[2]);
      write_csr(pfc_pkg::CsrSquareRow3, sq[3]);
      write_csr(pfc_pkg::CsrSquareRow4, sq[4]);
      write_csr($urandom_range(CsrFirstUnused, CsrLastUnused),
                pfc_pkg::RowWidth'($urandom()));
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LimitCycles) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      table_answer_type hint;
      pfc_pkg::rsp_type want;
      pfc_pkg::rsp_type got;
      if (!reset) begin
         if (csr_valid && csr_ready && csr_index <= pfc_pkg::CsrSquareRow4) begin
            key_rows[csr_index] = csr_wdata;
         end
         if (req_valid && req_ready) begin
            hint = '{typed: 1'b0, answer: '0};
            if (table_answers.size() != 0) hint = table_answers.pop_front();
            if (hint.typed) cipher_results_due.push_back(hint.answer);
            else cipher_results_due.push_back(cipher_pair(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (cipher_results_due.size() == 0) begin
               report_mismatch("result beat with no pair outstanding");
            end else begin
               want = cipher_results_due.pop_front();
               if (got.out_first !== want.out_first)
                  report_mismatch($sformatf("out_first got %0d want %0d",
                                            got.out_first, want.out_first));
               if (got.out_second !== want.out_second)
                  report_mismatch($sformatf("out_second got %0d want %0d",
                                            got.out_second, want.out_second));
               if (got.letter_missing !== want.letter_missing)
                  report_mismatch($sformatf("letter_missing got %0b want %0b",
                                            got.letter_missing, want.letter_missing));
               if (got.last_out !== want.last_out)
                  report_mismatch($sformatf("last_out got %0b want %0b",
                                            got.last_out, want.last_out));
            end
            results_checked++;
         end
      end
   end

   initial begin
      vector_row_type  directed_rows[$];
      square_kind_type phase_plan[12];
      int              send_pcts[3];
      int              take_pcts[3];

      send_pcts = '{21, 50, 0};
      take_pcts = '{50, 21, 0};
      phase_plan = '{SqShuffled, SqZeros, SqShuffled, SqRandom, SqShuffled, SqOnes,
                     SqReset, SqShuffled, SqRandom, SqShuffled, SqShuffled, SqReset};

      // reset square: a-e / f-j / k-o / p r s t u / v-z, q absent
      directed_rows = '{
         vec(0, 25, pfc_pkg::MODE_ENCRYPT, 1'b0, 1'b1, 4, 21),
         vec(0, 25, pfc_pkg::MODE_DECRYPT, 1'b1, 1'b1, 4, 21),
         vec(4, 0, pfc_pkg::MODE_ENCRYPT, 1'b0, 1'b1, 0, 1),
         vec(0, 4, pfc_pkg::MODE_DECRYPT, 1'b0, 1'b1, 4, 3),
         vec(21, 0, pfc_pkg::MODE_ENCRYPT, 1'b1, 1'b1, 0, 5),
         vec(0, 5, pfc_pkg::MODE_DECRYPT, 1'b0, 1'b1, 21, 0),
         vec(25, 25, pfc_pkg::MODE_ENCRYPT, 1'b0, 1'b1, 4, 4),
         vec(0, 0, pfc_pkg::MODE_DECRYPT, 1'b1, 1'b1, 21, 21),
         vec(16, 0, pfc_pkg::MODE_ENCRYPT, 1'b0, 1'b1, 0, 0, LetterAbsent),
         vec(0, 16, pfc_pkg::MODE_DECRYPT, 1'b0, 1'b1, 0, 0, LetterAbsent),
         vec(31, 31, pfc_pkg::MODE_ENCRYPT, 1'b1, 1'b1, 0, 0, LetterAbsent),
         vec(26, 25, pfc_pkg::MODE_DECRYPT, 1'b0, 1'b1, 0, 0, LetterAbsent),
         vec(12, 19, pfc_pkg::MODE_ENCRYPT, 1'b0),
         vec(7, 12, pfc_pkg::MODE_ENCRYPT, 1'b1),
         vec(10, 14, pfc_pkg::MODE_DECRYPT, 1'b0),
         vec(15, 20, pfc_pkg::MODE_ENCRYPT, 1'b0),
         vec(24, 3, pfc_pkg::MODE_DECRYPT, 1'b1),
         vec(17, 17, pfc_pkg::MODE_ENCRYPT, 1'b0),
         vec(1, 23, pfc_pkg::MODE_DECRYPT, 1'b0)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = send_pcts[0];
      take_idle_pct = take_pcts[0];
      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].answer);
      req_valid <= 1'b0;

      for (int regime = 0; regime < 3; regime++) begin
         send_idle_pct = send_pcts[regime];
         take_idle_pct = take_pcts[regime];
         for (int ph = 0; ph < 4; ph++) begin
            load_square(make_square(phase_plan[regime*4 + ph]));
            repeat (PairsPerPhase) send_pair(random_pair());
            req_valid <= 1'b0;
         end
      end

      while (results_checked != pairs_sent) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
